// ----- sv/dtt_pkg.sv -----
// Shared types and constants of the deadline timer table.
package dtt_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = $clog2(NUM_TIMERS);
  localparam int MAX_OUT    = 16;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam logic [31:0] THRESHOLD_RESET = 32'd3600000;  // one hour in ms

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CANCEL  = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;
  localparam logic [2:0] OP_COLLECT = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RST2, S_SEL, S_SCAN, S_DONE, S_OUT, S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    logic              act_set;
    logic              act_clr;
    logic              rec_we;
    logic              rec;
    logic              per_we;
    logic [31:0]       per;
    logic              dl_we;
    logic [63:0]       dl;
  } slot_wr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        notify;
    logic [63:0] ttn;
    logic        fired;
    logic        last;
  } res_t;

endpackage

// ----- sv/dtt_slot_store.sv -----
// Timer slot storage: active and mode bits, period and deadline arrays.
module dtt_slot_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dtt_pkg::slot_wr_t          wr_i,
  input  logic [dtt_pkg::SLOT_W-1:0] rd_idx_i,
  output logic [31:0]                period_o,
  output logic [63:0]                deadline_o,
  output logic [dtt_pkg::NUM_TIMERS-1:0] active_o,
  output logic [dtt_pkg::NUM_TIMERS-1:0] recur_o
);
  import dtt_pkg::*;

  logic [NUM_TIMERS-1:0] active_q, recur_q;
  logic [31:0] period_q [NUM_TIMERS];
  logic [63:0] deadline_q [NUM_TIMERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      recur_q  <= '0;
    end else begin
      if (wr_i.act_set) active_q[wr_i.idx] <= 1'b1;
      if (wr_i.act_clr) active_q[wr_i.idx] <= 1'b0;
      if (wr_i.rec_we)  recur_q[wr_i.idx]  <= wr_i.rec;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.per_we) period_q[wr_i.idx] <= wr_i.per;
    if (wr_i.dl_we)  deadline_q[wr_i.idx] <= wr_i.dl;
  end

  assign period_o   = period_q[rd_idx_i];
  assign deadline_o = deadline_q[rd_idx_i];
  assign active_o   = active_q;
  assign recur_o    = recur_q;

endmodule

// ----- sv/dtt_seq.sv -----
// Command sequencer with 64-bit add/compare logic and slot scan.
module dtt_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     operation_i,
  input  logic [3:0]                     slot_id_i,
  input  logic [31:0]                    period_ms_i,
  input  logic                           repeat_mode_i,
  input  logic                           from_now_i,
  input  logic [63:0]                    now_ms_i,
  input  logic [31:0]                    threshold_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output dtt_pkg::res_t                  res_o,
  output dtt_pkg::slot_wr_t              wr_o,
  output logic [dtt_pkg::SLOT_W-1:0]     rd_idx_o,
  input  logic [31:0]                    period_i,
  input  logic [63:0]                    deadline_i,
  input  logic [dtt_pkg::NUM_TIMERS-1:0] active_i,
  input  logic [dtt_pkg::NUM_TIMERS-1:0] recur_i
);
  import dtt_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_TIMERS - 1);

  seq_state_e state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [3:0]  sid_q, sid_d;
  logic [31:0] per_q, per_d;
  logic        rep_q, rep_d, fnow_q, fnow_d;
  logic [63:0] now_q, now_d, start_q, start_d, best_dl_q, best_dl_d, lct_q, lct_d;
  logic [SLOT_W-1:0] idx_q, idx_d, best_q, best_d, tgt_q, tgt_d;
  logic        best_vld_q, best_vld_d, pend_q, pend_d, rb_q, rb_d;
  logic [NUM_TIMERS-1:0] sel_q, sel_d, mask, best_oh;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  res_t        res_q, res_d;

  logic [SLOT_W-1:0] sid_idx, free_idx;
  logic        sid_ok, hit, free_found;

  assign sid_idx = SLOT_W'(sid_q);
  assign sid_ok  = 32'(sid_q) < NUM_TIMERS;
  assign hit     = sid_ok && active_i[sid_idx];
  assign mask    = (op_q == OP_COLLECT) ? sel_q : active_i;
  assign best_oh = NUM_TIMERS'(1) << best_q;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active_i[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      lct_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      lct_q   <= lct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  sid_q <= sid_d;  per_q <= per_d;  rep_q <= rep_d;
    fnow_q <= fnow_d;  now_q <= now_d;  start_q <= start_d;
    best_dl_q <= best_dl_d;  idx_q <= idx_d;  best_q <= best_d;  tgt_q <= tgt_d;
    best_vld_q <= best_vld_d;  rb_q <= rb_d;  sel_q <= sel_d;  cnt_q <= cnt_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;  op_d = op_q;  sid_d = sid_q;  per_d = per_q;  rep_d = rep_q;
    fnow_d = fnow_q;  now_d = now_q;  start_d = start_q;  best_dl_d = best_dl_q;
    idx_d = idx_q;  best_d = best_q;  tgt_d = tgt_q;  best_vld_d = best_vld_q;
    pend_d = pend_q;  rb_d = rb_q;  sel_d = sel_q;  cnt_d = cnt_q;  lct_d = lct_q;
    res_d = res_q;
    wr_o = '0;
    wr_o.idx = sid_idx;
    rd_idx_o = sid_idx;
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i;  sid_d = slot_id_i;  per_d = period_ms_i;
          rep_d = repeat_mode_i;  fnow_d = from_now_i;  now_d = now_ms_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d = '0;
        res_d.last = 1'b1;
        idx_d = '0;
        best_vld_d = 1'b0;
        state_d = S_OUT;
        unique case (op_q)
          OP_ADD: begin
            if (!free_found) begin
              res_d.status = ST_FULL;
            end else begin
              wr_o.idx = free_idx;
              wr_o.act_set = 1'b1;
              wr_o.rec_we = 1'b1;  wr_o.rec = rep_q;
              wr_o.per_we = 1'b1;  wr_o.per = per_q;
              wr_o.dl_we = 1'b1;   wr_o.dl = now_q + 64'(per_q);
              tgt_d = free_idx;
              res_d.slot = 4'(free_idx);
              state_d = S_SCAN;
            end
          end
          OP_CANCEL: begin
            if (!hit) res_d.status = ST_INACTIVE;
            else wr_o.act_clr = 1'b1;
          end
          OP_REFRESH: begin
            if (!hit) begin
              res_d.status = ST_INACTIVE;
            end else begin
              wr_o.dl_we = 1'b1;
              wr_o.dl = now_q + 64'(period_i);
            end
          end
          OP_RESET: begin
            if (hit && !(per_q == period_i && !fnow_q)) begin
              start_d = fnow_q ? now_q : deadline_i - 64'(period_i);
              state_d = S_RST2;
            end
          end
          OP_QUERY: begin
            pend_d = 1'b0;
            state_d = S_SCAN;
          end
          OP_COLLECT: begin
            if (active_i == '0) begin
              state_d = S_IDLE;
            end else begin
              rb_d = (now_q < lct_q) && ((lct_q - now_q) > 64'(threshold_i));
              lct_d = now_q;
              sel_d = '0;
              cnt_d = '0;
              state_d = S_SEL;
            end
          end
          default: ;
        endcase
      end
      S_RST2: begin
        wr_o.per_we = 1'b1;  wr_o.per = per_q;
        wr_o.dl_we = 1'b1;   wr_o.dl = start_q + 64'(per_q);
        tgt_d = sid_idx;
        state_d = S_SCAN;
      end
      S_SEL: begin
        rd_idx_o = idx_q;
        sel_d[idx_q] = active_i[idx_q] && (rb_q || deadline_i <= now_q);
        if (idx_q == LAST_IDX) begin
          idx_d = '0;
          best_vld_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN: begin
        // one slot per cycle through the scan comparator; strict < keeps lower slot
        rd_idx_o = idx_q;
        if (mask[idx_q] && (!best_vld_q || deadline_i < best_dl_q)) begin
          best_vld_d = 1'b1;
          best_d = idx_q;
          best_dl_d = deadline_i;
        end
        if (idx_q == LAST_IDX) state_d = S_DONE;
        else idx_d = idx_q + 1'b1;
      end
      S_DONE: begin
        state_d = S_OUT;
        unique case (op_q)
          OP_QUERY: begin
            if (!best_vld_q) res_d.ttn = '1;
            else if (now_q >= best_dl_q) res_d.ttn = '0;
            else res_d.ttn = best_dl_q - now_q;
          end
          OP_COLLECT: begin
            if (!best_vld_q) begin
              state_d = S_IDLE;
            end else begin
              res_d = '0;
              res_d.fired = 1'b1;
              res_d.slot = 4'(best_q);
              res_d.last = ((sel_q & ~best_oh) == '0) || (cnt_q == CNT_W'(MAX_OUT - 1));
              state_d = S_EMIT;
            end
          end
          default: begin
            if (best_vld_q && best_q == tgt_q && !pend_q) begin
              res_d.notify = 1'b1;
              pend_d = 1'b1;
            end
          end
        endcase
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        rd_idx_o = best_q;
        if (res_ready_i) begin
          wr_o.idx = best_q;
          if (recur_i[best_q]) begin
            wr_o.dl_we = 1'b1;
            wr_o.dl = now_q + 64'(period_i);
          end else begin
            wr_o.act_clr = 1'b1;
          end
          sel_d[best_q] = 1'b0;
          cnt_d = cnt_q + 1'b1;
          idx_d = '0;
          best_vld_d = 1'b0;
          state_d = res_q.last ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o = res_q;

endmodule

// ----- sv/deadline_timer_table_unit.sv -----
// Top level of the deadline timer table: threshold register, sequencer, output register.
// Usage:
//   Command channel (in_valid_i/in_ready_o) carries one beat per command:
//   operation, slot, period, mode, from-now flag and the current time.
//   Result channel (out_valid_o/out_ready_i) returns one beat per command,
//   or one beat per expired timer on collect (none if nothing expired);
//   last_o marks the final beat of a command.
//   cfg_we_i writes the rollback threshold; write it only while idle.
// Sequencing (N = 16 slots, one slot per cycle through one 64-bit comparator):
//   cancel, refresh, unknown op, add on a full table, reset that changes
//   nothing: execute step, then the beat goes to the output register.
//   add, query: execute, slot scan, done; reset adds a write step before the scan.
//   collect: an expiry pass over all slots and a scan (no beat on an empty table),
//   then a slot scan and a beat per expired timer.
//   The slot scan sets the rate; one command is in work at a time.
// Reset: all timers inactive, notification clear, last check time zero,
//   threshold 3600000 ms. No clearing pass.
// Stall: the output register holds a beat while out_ready_i is low; the
//   sequencer accepts a new command once its last beat is in that register,
//   and a multi-beat collect waits for each beat to drain.
module deadline_timer_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  slot_id_i,
  input  logic [31:0] period_ms_i,
  input  logic        repeat_mode_i,
  input  logic        from_now_i,
  input  logic [63:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  result_slot_o,
  output logic        front_notify_o,
  output logic [63:0] time_to_next_o,
  output logic        fired_o,
  output logic        last_o
);
  import dtt_pkg::*;

  logic [31:0] thr_q;
  logic        out_valid_q;
  res_t        out_q, res;
  logic        res_valid, res_ready;
  slot_wr_t    wr;
  logic [SLOT_W-1:0] rd_idx;
  logic [31:0] period;
  logic [63:0] deadline;
  logic [NUM_TIMERS-1:0] active, recur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (res_ready) out_valid_q <= res_valid;
    end
  end

  // output register: loads whenever empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  dtt_slot_store u_store (
    .clk_i, .rst_ni,
    .wr_i       (wr),
    .rd_idx_i   (rd_idx),
    .period_o   (period),
    .deadline_o (deadline),
    .active_o   (active),
    .recur_o    (recur)
  );

  dtt_seq u_seq (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .operation_i, .slot_id_i, .period_ms_i, .repeat_mode_i, .from_now_i, .now_ms_i,
    .threshold_i (thr_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_o        (wr),
    .rd_idx_o    (rd_idx),
    .period_i    (period),
    .deadline_i  (deadline),
    .active_i    (active),
    .recur_i     (recur)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_slot_o  = out_q.slot;
  assign front_notify_o = out_q.notify;
  assign time_to_next_o = out_q.ttn;
  assign fired_o        = out_q.fired;
  assign last_o         = out_q.last;

endmodule

// ----- sv/dtt_checker.sv -----
// Port-level checks of the deadline timer table and their bind.
module dtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [3:0]  result_slot_o,
  input logic        front_notify_o,
  input logic [63:0] time_to_next_o,
  input logic        fired_o,
  input logic        last_o
);
  import dtt_pkg::*;

  // the sequencer is not ready again right after it accepts a command
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_o |-> status_o == ST_OK && !front_notify_o &&
    time_to_next_o == '0) else $error("fired beat carries other fields");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fired_o |-> last_o) else $error("non-collect beat not last");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_slot_o == '0 && !front_notify_o)
    else $error("error beat with slot or notify");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_slot_o) &&
    $stable(time_to_next_o) && $stable(last_o)) else $error("stalled beat changed");

endmodule

bind deadline_timer_table_unit dtt_checker u_dtt_checker (.*);
